// ----- src/gca_pkg.sv -----
package gca_pkg;

   localparam int CODE_LENGTH     = 1023;
   localparam int SAMPLE_WIDTH    = 12;
   localparam int SATELLITE_COUNT = 24;

   localparam int IDX_WIDTH    = 10;
   localparam int SAT_WIDTH    = 5;
   localparam int THR_WIDTH    = 21;
   localparam int ACC_WIDTH    = (SAMPLE_WIDTH + IDX_WIDTH + 1 > THR_WIDTH + 1)
                                 ? SAMPLE_WIDTH + IDX_WIDTH + 1 : THR_WIDTH + 1;
   localparam int LFSR_WIDTH   = 10;
   localparam int REQ_WIDTH    = ((IDX_WIDTH + SAMPLE_WIDTH + SAT_WIDTH + 7) / 8) * 8;
   localparam int RSP_WIDTH    = ((SAT_WIDTH + 2 + IDX_WIDTH + 7) / 8) * 8;

   localparam logic [IDX_WIDTH-1:0]  LAST_IDX      = IDX_WIDTH'(CODE_LENGTH - 1);
   localparam logic [THR_WIDTH-1:0]  THRESH_RESET  = THR_WIDTH'(200);
   localparam logic [LFSR_WIDTH-1:0] LFSR_SEED     = '1;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SEARCH = 1'b1;

   // G2 output taps per satellite, numbered 1..10 from the input end
   localparam logic [3:0] G2_TAP_A [SATELLITE_COUNT] = '{
      4'd2, 4'd3, 4'd4, 4'd5, 4'd1, 4'd2, 4'd1, 4'd2,
      4'd3, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd1, 4'd4};
   localparam logic [3:0] G2_TAP_B [SATELLITE_COUNT] = '{
      4'd6,  4'd7, 4'd8, 4'd9, 4'd9, 4'd10, 4'd8, 4'd9,
      4'd10, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8,  4'd9, 4'd10,
      4'd4,  4'd5, 4'd6, 4'd7, 4'd8, 4'd9,  4'd3, 4'd6};

   function automatic logic [LFSR_WIDTH-1:0] g2_tap_mask(input logic [SAT_WIDTH-1:0] sat);
      logic [SAT_WIDTH-1:0] sel;
      logic [3:0]           ta;
      logic [3:0]           tb;
      sel = sat - SAT_WIDTH'(1);
      ta  = G2_TAP_A[sel];
      tb  = G2_TAP_B[sel];
      return (LFSR_WIDTH'(1) << (4'(LFSR_WIDTH) - ta)) |
             (LFSR_WIDTH'(1) << (4'(LFSR_WIDTH) - tb));
   endfunction

endpackage

// ----- src/gps_ca_code_correlator_core.sv -----
// Load transaction: no result; loads can follow back to back.
// Search: build the code, then per delay accumulate, drain and compare, until the first
// delay over the threshold or the last delay; then post the result to rsp_tvalid.
// Out-of-range satellite: no code is built. Not ready from acceptance until the result is posted;
// a result still held by the receiver stalls the posting.
// Reset: synchronous active high; threshold returns to 200, LFSRs to all ones, memories kept.
module gps_ca_code_correlator_core
   import gca_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,   // action
   input  logic [REQ_WIDTH-1:0] req_tdata,   // chip_index, chip_value, satellite_number, pad
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_WIDTH-1:0] rsp_tdata,   // result_satellite, found, data_bit, code_delay, pad
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [THR_WIDTH-1:0] csr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_BUILD  = 3'd1;
   localparam logic [2:0] ST_ACC    = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_CHECK  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [IDX_WIDTH-1:0]    req_index;
   logic [SAMPLE_WIDTH-1:0] req_value;
   logic [SAT_WIDTH-1:0]    req_sat;
   logic                    req_fire;

   logic [2:0]              state_ff, state_in;
   logic [IDX_WIDTH-1:0]    cnt_ff, cnt_in;
   logic [IDX_WIDTH-1:0]    pos_ff, pos_in;
   logic [IDX_WIDTH-1:0]    dly_ff, dly_in;
   logic [ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic                    acc_vld_ff;
   logic [LFSR_WIDTH-1:0]   g1_ff, g1_in;
   logic [LFSR_WIDTH-1:0]   g2_ff, g2_in;
   logic [LFSR_WIDTH-1:0]   mask_ff, mask_in;
   logic [SAT_WIDTH-1:0]    sat_ff, sat_in;
   logic                    fin_found_ff, fin_found_in;
   logic                    fin_bit_ff, fin_bit_in;
   logic [IDX_WIDTH-1:0]    fin_dly_ff, fin_dly_in;
   logic [THR_WIDTH-1:0]    thresh_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0]    rsp_data_ff, rsp_data_in;

   logic [SAMPLE_WIDTH-1:0] chip_mem [CODE_LENGTH];
   logic                    code_mem [CODE_LENGTH];
   logic [SAMPLE_WIDTH-1:0] chip_rd_ff;
   logic                    code_rd_ff;

   logic                    code_bit;
   logic                    g1_fb;
   logic                    g2_fb;
   logic [ACC_WIDTH-1:0]    addend;
   logic [ACC_WIDTH-1:0]    mag;
   logic                    hit;
   logic                    sat_ok;

   assign req_index  = req_tdata[IDX_WIDTH-1:0];
   assign req_value  = req_tdata[IDX_WIDTH+SAMPLE_WIDTH-1:IDX_WIDTH];
   assign req_sat    = req_tdata[IDX_WIDTH+SAMPLE_WIDTH+SAT_WIDTH-1:IDX_WIDTH+SAMPLE_WIDTH];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign sat_ok   = (req_sat >= SAT_WIDTH'(1)) && (req_sat <= SAT_WIDTH'(SATELLITE_COUNT));
   assign code_bit = g1_ff[0] ^ (^(g2_ff & mask_ff));
   assign g1_fb    = g1_ff[0] ^ g1_ff[7];
   assign g2_fb    = g2_ff[0] ^ g2_ff[1] ^ g2_ff[2] ^ g2_ff[4] ^ g2_ff[7] ^ g2_ff[8];
   assign addend   = code_rd_ff
                     ? {{(ACC_WIDTH-SAMPLE_WIDTH){chip_rd_ff[SAMPLE_WIDTH-1]}}, chip_rd_ff}
                     : '0;
   assign mag      = acc_ff[ACC_WIDTH-1] ? (~acc_ff + ACC_WIDTH'(1)) : acc_ff;
   assign hit      = mag > {{(ACC_WIDTH-THR_WIDTH){1'b0}}, thresh_ff};

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      dly_in       = dly_ff;
      acc_in       = acc_vld_ff ? (acc_ff + addend) : acc_ff;
      g1_in        = g1_ff;
      g2_in        = g2_ff;
      mask_in      = mask_ff;
      sat_in       = sat_ff;
      fin_found_in = fin_found_ff;
      fin_bit_in   = fin_bit_ff;
      fin_dly_in   = fin_dly_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser == ACTION_SEARCH) begin
               sat_in       = req_sat;
               g1_in        = LFSR_SEED;
               g2_in        = LFSR_SEED;
               cnt_in       = '0;
               fin_found_in = 1'b0;
               fin_bit_in   = 1'b0;
               fin_dly_in   = '0;
               if (sat_ok) begin
                  mask_in  = g2_tap_mask(req_sat);
                  state_in = ST_BUILD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_BUILD: begin
            g1_in  = {g1_fb, g1_ff[LFSR_WIDTH-1:1]};
            g2_in  = {g2_fb, g2_ff[LFSR_WIDTH-1:1]};
            cnt_in = cnt_ff + IDX_WIDTH'(1);
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               pos_in   = '0;
               dly_in   = '0;
               acc_in   = '0;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cnt_in = cnt_ff + IDX_WIDTH'(1);
            pos_in = (pos_ff == LAST_IDX) ? '0 : pos_ff + IDX_WIDTH'(1);
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (hit) begin
               fin_found_in = 1'b1;
               fin_bit_in   = !acc_ff[ACC_WIDTH-1];
               fin_dly_in   = dly_ff;
               state_in     = ST_FINISH;
            end else if (dly_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end else begin
               dly_in   = dly_ff + IDX_WIDTH'(1);
               pos_in   = dly_ff + IDX_WIDTH'(1);
               cnt_in   = '0;
               acc_in   = '0;
               state_in = ST_ACC;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_WIDTH'({fin_dly_ff, fin_bit_ff, fin_found_ff, sat_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= THRESH_RESET;
         g1_ff        <= LFSR_SEED;
         g2_ff        <= LFSR_SEED;
      end else begin
         state_ff     <= state_in;
         acc_vld_ff   <= (state_ff == ST_ACC);
         rsp_valid_ff <= rsp_valid_in;
         g1_ff        <= g1_in;
         g2_ff        <= g2_in;
         if (csr_valid && csr_ready) begin
            thresh_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      pos_ff       <= pos_in;
      dly_ff       <= dly_in;
      acc_ff       <= acc_in;
      mask_ff      <= mask_in;
      sat_ff       <= sat_in;
      fin_found_ff <= fin_found_in;
      fin_bit_ff   <= fin_bit_in;
      fin_dly_ff   <= fin_dly_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // sample and code memories
   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == ACTION_LOAD && req_index <= LAST_IDX) begin
         chip_mem[req_index] <= req_value;
      end
      if (state_ff == ST_BUILD) begin
         code_mem[cnt_ff] <= code_bit;
      end
      chip_rd_ff <= chip_mem[pos_ff];
      code_rd_ff <= code_mem[cnt_ff];
   end

endmodule

// ----- verif/gps_ca_code_correlator_checker.sv -----
module gps_ca_code_correlator_checker
   import gca_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic                 req_tuser,   // action
   input  logic [REQ_WIDTH-1:0] req_tdata,   // chip_index, chip_value, satellite_number, pad
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [RSP_WIDTH-1:0] rsp_tdata,   // result_satellite, found, data_bit, code_delay, pad
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [THR_WIDTH-1:0] csr_data,
   output int                   fail_count,
   output int                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_LSB = IDX_WIDTH;
   localparam int SAT_LSB   = IDX_WIDTH + SAMPLE_WIDTH;
   localparam int FOUND_POS = SAT_WIDTH;
   localparam int BIT_POS   = SAT_WIDTH + 1;
   localparam int DELAY_LSB = SAT_WIDTH + 2;

   typedef struct {
      logic [SAT_WIDTH-1:0] satellite;
      logic                 found;
      logic                 data_bit;
      logic [IDX_WIDTH-1:0] delay;
   } acq_result_type;

   logic signed [SAMPLE_WIDTH-1:0] chip_samples [CODE_LENGTH];
   logic [THR_WIDTH-1:0]           threshold;
   int                             code_ones [$];
   acq_result_type                 acq_expected_q [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      threshold     = THRESH_RESET;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   // positions of the ones in the satellite's C/A code
   function automatic void build_ca_code(input int sat);
      logic [LFSR_WIDTH-1:0] g1;
      logic [LFSR_WIDTH-1:0] g2;
      int                    ta;
      int                    tb;
      ta = int'(G2_TAP_A[sat - 1]);
      tb = int'(G2_TAP_B[sat - 1]);
      g1 = LFSR_SEED;
      g2 = LFSR_SEED;
      code_ones.delete();
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (g1[0] ^ g2[LFSR_WIDTH - ta] ^ g2[LFSR_WIDTH - tb]) begin
            code_ones.push_back(i);
         end
         g1 = {g1[0] ^ g1[7], g1[LFSR_WIDTH-1:1]};
         g2 = {g2[0] ^ g2[1] ^ g2[2] ^ g2[4] ^ g2[7] ^ g2[8], g2[LFSR_WIDTH-1:1]};
      end
   endfunction

   function automatic acq_result_type correlate_satellite(input logic [SAT_WIDTH-1:0] sat);
      acq_result_type res;
      longint         sum;
      longint         mag;
      int             pos;
      res.satellite = sat;
      res.found     = 1'b0;
      res.data_bit  = 1'b0;
      res.delay     = '0;
      if (sat == 0 || sat > SATELLITE_COUNT) begin
         return res;
      end
      build_ca_code(int'(sat));
      for (int d = 0; d < CODE_LENGTH; d++) begin
         sum = 0;
         foreach (code_ones[k]) begin
            pos = d + code_ones[k];
            if (pos >= CODE_LENGTH) begin
               pos -= CODE_LENGTH;
            end
            sum += chip_samples[pos];
         end
         mag = (sum < 0) ? -sum : sum;
         if (mag > longint'(threshold)) begin
            res.found    = 1'b1;
            res.data_bit = (sum > 0);
            res.delay    = IDX_WIDTH'(d);
            return res;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      acq_result_type got;
      acq_result_type want;
      if (reset) begin
         threshold = THRESH_RESET;
         acq_expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            threshold = csr_data;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == ACTION_SEARCH) begin
               acq_expected_q.push_back(correlate_satellite(req_tdata[SAT_LSB +: SAT_WIDTH]));
            end else if (req_tdata[IDX_WIDTH-1:0] <= LAST_IDX) begin
               chip_samples[req_tdata[IDX_WIDTH-1:0]] = req_tdata[VALUE_LSB +: SAMPLE_WIDTH];
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.satellite = rsp_tdata[SAT_WIDTH-1:0];
            got.found     = rsp_tdata[FOUND_POS];
            got.data_bit  = rsp_tdata[BIT_POS];
            got.delay     = rsp_tdata[DELAY_LSB +: IDX_WIDTH];
            if (acq_expected_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result transaction, satellite %0d",
                                         got.satellite));
            end else begin
               want = acq_expected_q.pop_front();
               if (got.satellite !== want.satellite) begin
                  report_mismatch($sformatf("result_satellite %0d, expected %0d",
                                            got.satellite, want.satellite));
               end
               if (got.found !== want.found) begin
                  report_mismatch($sformatf("sat %0d: found %0b, expected %0b",
                                            want.satellite, got.found, want.found));
               end
               if (got.data_bit !== want.data_bit) begin
                  report_mismatch($sformatf("sat %0d: data_bit %0b, expected %0b",
                                            want.satellite, got.data_bit, want.data_bit));
               end
               if (got.delay !== want.delay) begin
                  report_mismatch($sformatf("sat %0d: code_delay %0d, expected %0d",
                                            want.satellite, got.delay, want.delay));
               end
            end
         end
      end
      pending_count = acq_expected_q.size();
   end

endmodule

// ----- verif/gps_ca_code_correlator_core_tb.sv -----
module gps_ca_code_correlator_core_tb
   import gca_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint SEARCH_WORST_CYCLES =
      longint'(CODE_LENGTH) * (CODE_LENGTH + 2) + CODE_LENGTH + 64;
   localparam longint ITEM_SLACK       = 32;
   localparam longint BASE_CYCLES      = 100000;
   localparam int     LONG_HOLD_CYCLES = 6000;
   localparam int     IDLE_SETTLE      = 16;
   localparam int     DRAIN_CYCLES     = 64;
   localparam int     RANDOM_PHASES    = 8;
   localparam int     ITEMS_PER_PHASE  = 13;
   localparam logic [THR_WIDTH-1:0] THRESH_MAX = THR_WIDTH'(2095104);

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic                 req_tuser;   // action
   logic [REQ_WIDTH-1:0] req_tdata;   // chip_index, chip_value, satellite_number, pad
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_WIDTH-1:0] rsp_tdata;   // result_satellite, found, data_bit, code_delay, pad
   logic                 csr_valid;
   logic                 csr_ready;
   logic [THR_WIDTH-1:0] csr_data;

   int     fail_count;
   int     pending_count;
   logic   quiet        = 1'b0;
   logic   hold_results = 1'b0;
   longint cycle_budget = 0;
   longint cycle_count  = 0;

   gps_ca_code_correlator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   gps_ca_code_correlator_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side backpressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
            hold_results = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cycle_budget <= cycle_budget + ITEM_SLACK +
                         ((req_tuser == ACTION_SEARCH) ? SEARCH_WORST_CYCLES : 1);
      end
   end

   initial begin
      while (cycle_count <= 4 * cycle_budget + BASE_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("gps_ca_code_correlator_core_tb NOT OK");
      $finish;
   end

   task automatic send_item(input logic action, input logic [REQ_WIDTH-1:0] payload);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = action;
      req_tdata  = payload;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic load_chip(input logic [IDX_WIDTH-1:0] idx,
                            input logic [SAMPLE_WIDTH-1:0] value);
      send_item(ACTION_LOAD, REQ_WIDTH'({SAT_WIDTH'($urandom), value, idx}));
   endtask

   task automatic search_satellite(input logic [SAT_WIDTH-1:0] sat);
      send_item(ACTION_SEARCH,
                REQ_WIDTH'({sat, SAMPLE_WIDTH'($urandom), IDX_WIDTH'($urandom)}));
   endtask

   task automatic fill_chips(input logic random_values, input logic [SAMPLE_WIDTH-1:0] level);
      for (int i = 0; i < CODE_LENGTH; i++) begin
         load_chip(IDX_WIDTH'(i), random_values ? SAMPLE_WIDTH'($urandom) : level);
      end
   endtask

   task automatic wait_idle();
      while (pending_count != 0) @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [THR_WIDTH-1:0] value);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = ACTION_LOAD;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // satellites outside 1..24 build no code and read no chips
      search_satellite(SAT_WIDTH'(0));
      search_satellite(SAT_WIDTH'(25));
      search_satellite(SAT_WIDTH'(31));

      // full-scale negative signal: largest magnitude sum
      fill_chips(1'b0, SAMPLE_WIDTH'(-2048));
      wait_idle();
      write_threshold(THR_WIDTH'(1048575));
      search_satellite(SAT_WIDTH'(1));
      wait_idle();
      write_threshold(THRESH_MAX);
      search_satellite(SAT_WIDTH'(24));

      // full-scale positive; out-of-range index must not land anywhere
      fill_chips(1'b0, SAMPLE_WIDTH'(2047));
      load_chip(IDX_WIDTH'(1023), SAMPLE_WIDTH'(-2048));
      wait_idle();
      write_threshold(THR_WIDTH'(1048063));
      search_satellite(SAT_WIDTH'(13));

      fill_chips(1'b1, '0);
      wait_idle();
      write_threshold('0);
      search_satellite(SAT_WIDTH'(1));
      search_satellite(SAT_WIDTH'(24));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         quiet = (phase == RANDOM_PHASES - 1);
         // short searches while results are held, so the block backs up
         write_threshold((phase == 1) ? '0 : THR_WIDTH'($urandom_range(0, 20000)));
         if (phase == 1) begin
            hold_results = 1'b1;
         end
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) < 4) begin
               load_chip(IDX_WIDTH'($urandom_range(0, 1023)), SAMPLE_WIDTH'($urandom));
            end else if ($urandom_range(0, 7) == 0) begin
               search_satellite(SAT_WIDTH'($urandom_range(0, 31)));
            end else begin
               search_satellite(SAT_WIDTH'($urandom_range(1, SATELLITE_COUNT)));
            end
         end
      end

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("gps_ca_code_correlator_core_tb OK");
      end else begin
         $display("gps_ca_code_correlator_core_tb NOT OK");
      end
      $finish;
   end

endmodule
